// ===== sv/tdsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdsm_pkg: shared types and constants of the dissolved-solids converter
// Field widths, fixed-point coefficients, command codes and sequencer states.
// ----------------------------------------------------------------------------
package tdsm_pkg;

    // parameter defaults
    localparam int WINDOW_DEF   = 30;
    localparam int ADC_BITS_DEF = 10;

    // word field widths
    localparam int SAMPLE_W = 10;
    localparam int TEMP_W   = 11;
    localparam int TDS_W    = 20;
    localparam int MEDIAN_W = 10;

    // datapath widths
    localparam int NUM_W  = 28;   // v0 * 800, below 4000 * 2^16
    localparam int DEN_W  = 12;   // 400 + temperature
    localparam int V_W    = 20;   // compensated volts, Q4.16
    localparam int OPA_W  = 28;   // multiplier operand a (v, v2, v3)
    localparam int OPB_W  = 20;   // multiplier operand b (v or a coefficient)
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = 46;

    // constants of the conversion
    localparam logic [NUM_W-1:0] VOLT_SCALE = NUM_W'(4000);   // 5 V * 800
    localparam logic [DEN_W-1:0] TEMP_BIAS  = DEN_W'(400);
    localparam logic [OPB_W-1:0] COEF_A     = OPB_W'(34156);
    localparam logic [OPB_W-1:0] COEF_B     = OPB_W'(65500);
    localparam logic [OPB_W-1:0] COEF_C     = OPB_W'(219492);
    localparam logic [TDS_W-1:0] TDS_MAX_Q4 = TDS_W'(1048560);

    // command codes
    localparam logic CMD_PUSH    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT,
        ST_MED,
        ST_DIV,
        ST_MV2,
        ST_MV3,
        ST_MA,
        ST_MB,
        ST_MC,
        ST_SUM,
        ST_OUT
    } tdsm_state_t;

endpackage
`default_nettype wire

// ===== sv/tdsm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdsm_in_if: request channel
// Carries one command word: push a sample or compute a reading.
// ----------------------------------------------------------------------------
interface tdsm_in_if
    import tdsm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [SAMPLE_W-1:0] sample_code;
    logic [TEMP_W-1:0]   water_temp_q4;

    modport source (output valid, command, sample_code, water_temp_q4, input ready);
    modport sink   (input valid, command, sample_code, water_temp_q4, output ready);
endinterface
`default_nettype wire

// ===== sv/tdsm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdsm_out_if: result channel
// Carries one reading word: tds, median code and saturation flag.
// ----------------------------------------------------------------------------
interface tdsm_out_if
    import tdsm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [TDS_W-1:0]    tds_q4;
    logic [MEDIAN_W-1:0] median_code;
    logic                saturated;

    modport source (output valid, tds_q4, median_code, saturated, input ready);
    modport sink   (input valid, tds_q4, median_code, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/tds_median_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tds_median_converter: windowed median to dissolved-solids reading
// Keeps the last WINDOW samples, sorts them through a row of cells on
// request and converts the median to 1/16 ppm with compensation.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   words
//  req      in   command, sample_code, water_temp_q4       push or compute
//  rsp      out  tds_q4, median_code, saturated            one per compute
//
//  Push: shifts the sample into the window.
//  Compute: sorting (window rotates through the cell row), the median step,
//  the divider, the multiply/sum steps and the output load; the result word
//  becomes valid in the same cycle that the next req word can be taken.
//  Reset clears the window to zero samples at once; no clearing pass.
//  req is taken only between computes; a pending rsp word stalls only the
//  final load of the next compute.
// ----------------------------------------------------------------------------
module tds_median_converter
    import tdsm_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int ADC_BITS = ADC_BITS_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tdsm_in_if.sink    req,
    tdsm_out_if.source rsp
);

    localparam int CNT_W  = $clog2(2 * WINDOW);
    localparam int MID_HI = WINDOW / 2;
    localparam int MID_LO = WINDOW / 2 - 1;
    localparam bit ODD    = (WINDOW % 2) != 0;

    tdsm_state_t state_reg, state_next;

    logic [ADC_BITS-1:0] ring_reg [WINDOW];
    logic [CNT_W-1:0]    cnt_reg;
    logic [TEMP_W-1:0]   temp_reg;
    logic [ADC_BITS-1:0] med_reg;
    logic [V_W-1:0]      v_reg;
    logic [23:0]         v2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                out_vld_reg;
    logic [TDS_W-1:0]    tds_reg;
    logic [MEDIAN_W-1:0] med_out_reg;
    logic                sat_reg;

    // sequencer outputs
    logic             in_ready;
    logic             feed_vld;
    logic             sort_clear;
    logic             div_start;
    logic             load_out;
    logic [OPA_W-1:0] op_a;
    logic [OPB_W-1:0] op_b;

    logic                  accept;
    logic [ADC_BITS-1:0]   sample_val;
    logic [SAMPLE_W+ADC_BITS-1:0] sample_ext;
    logic [ADC_BITS:0]     mid_sum;
    logic [ADC_BITS-1:0]   med_val;
    logic [MEDIAN_W+ADC_BITS-1:0] med_ext;
    logic [NUM_W-1:0]      numer;
    logic [DEN_W-1:0]      denom;
    logic                  div_done;
    logic [NUM_W-1:0]      quotient;
    logic [PROD_W-1:0]     prod_next;
    logic                  acc_pos;
    logic [23:0]           tds_wide;
    logic                  tds_sat;

    // sorter row links: link 0 is the feed from the window
    logic                link_vld  [WINDOW+1];
    logic [ADC_BITS-1:0] link_data [WINDOW+1];
    logic [ADC_BITS-1:0] held      [WINDOW];
    logic                full      [WINDOW];

    assign accept     = req.valid && in_ready;
    assign sample_ext = {{ADC_BITS{1'b0}}, req.sample_code};
    assign sample_val = sample_ext[ADC_BITS-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.command == CMD_COMPUTE)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (cnt_reg == CNT_W'(2 * WINDOW - 1))
                begin
                    state_next = ST_MED;
                end
            end
            ST_MED: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MV2;
                end
            end
            ST_MV2: state_next = ST_MV3;
            ST_MV3: state_next = ST_MA;
            ST_MA:  state_next = ST_MB;
            ST_MB:  state_next = ST_MC;
            ST_MC:  state_next = ST_SUM;
            ST_SUM: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and multiplier operands
    always_comb
    begin
        in_ready   = 1'b0;
        feed_vld   = 1'b0;
        sort_clear = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        op_a       = '0;
        op_b       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                sort_clear = 1'b1;
            end
            ST_SORT: feed_vld  = cnt_reg < CNT_W'(WINDOW);
            ST_MED:  div_start = 1'b1;
            ST_MV2:
            begin
                op_a = OPA_W'(v_reg);
                op_b = v_reg;
            end
            ST_MV3:
            begin
                op_a = OPA_W'(prod_reg[39:16]);
                op_b = v_reg;
            end
            ST_MA:
            begin
                op_a = prod_reg[43:16];
                op_b = COEF_A;
            end
            ST_MB:
            begin
                op_a = OPA_W'(v2_reg);
                op_b = COEF_B;
            end
            ST_MC:
            begin
                op_a = OPA_W'(v_reg);
                op_b = COEF_C;
            end
            ST_OUT:  load_out = !out_vld_reg || rsp.ready;
            default: ;
        endcase
    end

    // state and sort counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SORT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // window: shift in on push, rotate into the sorter during sort
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (accept && req.command == CMD_PUSH)
        begin
            ring_reg[0] <= sample_val;
            for (int i = 1; i < WINDOW; i++)
            begin
                ring_reg[i] <= ring_reg[i-1];
            end
        end
        else if (feed_vld)
        begin
            ring_reg[0] <= ring_reg[WINDOW-1];
            for (int i = 1; i < WINDOW; i++)
            begin
                ring_reg[i] <= ring_reg[i-1];
            end
        end
    end

    // sorter row
    assign link_vld[0]  = feed_vld;
    assign link_data[0] = ring_reg[WINDOW-1];

    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        tdsm_sort_cell #(
            .DATA_W (ADC_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (sort_clear),
            .in_vld    (link_vld[g]),
            .in_data   (link_data[g]),
            .full      (full[g]),
            .held      (held[g]),
            .pass_vld  (link_vld[g+1]),
            .pass_data (link_data[g+1])
        );
    end

    // median from the middle cells
    assign mid_sum = {1'b0, held[MID_HI]} + {1'b0, held[MID_LO]};
    assign med_val = ODD ? held[MID_HI] : mid_sum[ADC_BITS:1];

    // volts times 800 over 400 + T
    assign numer = NUM_W'(NUM_W'(med_val) * VOLT_SCALE) << (16 - ADC_BITS);
    assign denom = TEMP_BIAS + DEN_W'(temp_reg);

    tdsm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer),
        .denom    (denom),
        .done     (div_done),
        .quotient (quotient)
    );

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    // datapath: capture, multiply and accumulate the cubic
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg <= req.water_temp_q4;
        end
        case (state_reg)
            ST_MED: med_reg <= med_val;
            ST_DIV: v_reg   <= quotient[V_W-1:0];
            ST_MV2: prod_reg <= prod_next;
            ST_MV3:
            begin
                v2_reg   <= prod_reg[39:16];
                prod_reg <= prod_next;
            end
            ST_MA: prod_reg <= prod_next;
            ST_MB:
            begin
                acc_reg  <= $signed({2'b00, prod_reg[43:0]});
                prod_reg <= prod_next;
            end
            ST_MC:
            begin
                acc_reg  <= acc_reg - $signed({2'b00, prod_reg[43:0]});
                prod_reg <= prod_next;
            end
            ST_SUM: acc_reg <= acc_reg + $signed({2'b00, prod_reg[43:0]});
            default: ;
        endcase
    end

    // scale to 1/16 ppm and clip
    assign acc_pos  = !acc_reg[ACC_W-1] && (acc_reg != '0);
    assign tds_wide = acc_reg[44:21];
    assign tds_sat  = acc_pos && (tds_wide > 24'(TDS_MAX_Q4));
    assign med_ext  = {{MEDIAN_W{1'b0}}, med_reg};

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            tds_reg     <= !acc_pos ? '0 : (tds_sat ? TDS_MAX_Q4 : tds_wide[TDS_W-1:0]);
            sat_reg     <= tds_sat;
            med_out_reg <= med_ext[MEDIAN_W-1:0];
        end
    end

    assign req.ready       = in_ready;
    assign rsp.valid       = out_vld_reg;
    assign rsp.tds_q4      = tds_reg;
    assign rsp.median_code = med_out_reg;
    assign rsp.saturated   = sat_reg;

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !link_vld[WINDOW])
        else $error("sorter row overflowed");

    a_row_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MED |-> full[0] && full[WINDOW-1])
        else $error("sorter row not filled at median");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide step");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result word loaded outside output step");

endmodule
`default_nettype wire

// ===== sv/tdsm_sort_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdsm_sort_cell: one cell of the systolic insertion sorter
// Keeps the smallest value seen since clear and hands the larger one on.
// ----------------------------------------------------------------------------
module tdsm_sort_cell
    import tdsm_pkg::*;
#(
    parameter int DATA_W = ADC_BITS_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              in_vld,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   full,
    output logic [DATA_W-1:0]      held,
    output logic                   pass_vld,
    output logic [DATA_W-1:0]      pass_data
);

    logic              full_reg;
    logic              pass_vld_reg;
    logic [DATA_W-1:0] held_reg;
    logic [DATA_W-1:0] pass_data_reg;
    logic              keep_in;

    assign keep_in = in_data < held_reg;

    // control: fill flag and pass strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else if (clear)
        begin
            full_reg     <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_vld)
            begin
                full_reg <= 1'b1;
            end
            pass_vld_reg <= in_vld && full_reg;
        end
    end

    // payload: hold the minimum, pass the maximum
    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            if (!full_reg)
            begin
                held_reg <= in_data;
            end
            else if (keep_in)
            begin
                held_reg      <= in_data;
                pass_data_reg <= held_reg;
            end
            else
            begin
                pass_data_reg <= in_data;
            end
        end
    end

    assign full      = full_reg;
    assign held      = held_reg;
    assign pass_vld  = pass_vld_reg;
    assign pass_data = pass_data_reg;

endmodule
`default_nettype wire

// ===== sv/tdsm_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdsm_divider: restoring divider for temperature compensation
// One quotient bit per cycle, NUM_W bits per division.
// ----------------------------------------------------------------------------
module tdsm_divider
    import tdsm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // control: bit counter and done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= denom;
            quo_reg <= numer;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
            end
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire
